@@ hdl/obdpid_pkg.sv @@
// Shared types and constants for the OBD-II mode 01 response decoder.
package obdpid_pkg;

	localparam int unsigned ID_W    = 29;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned QTY_W   = 4;
	localparam int unsigned VALUE_W = 23;
	localparam int unsigned MARKS_W = 9;

	localparam logic [ID_W-1:0]  RESPONSE_ID_RESET = 29'h7E8;
	localparam logic [LEN_W-1:0] MIN_LENGTH        = 4'd3;
	localparam logic [7:0]       MODE_RESPONSE     = 8'h41;

	localparam logic [7:0] PID_RPM      = 8'h0C;
	localparam logic [7:0] PID_SPEED    = 8'h0D;
	localparam logic [7:0] PID_THROTTLE = 8'h11;
	localparam logic [7:0] PID_FUEL     = 8'h2F;
	localparam logic [7:0] PID_COOLANT  = 8'h05;
	localparam logic [7:0] PID_LOAD     = 8'h04;
	localparam logic [7:0] PID_INTAKE   = 8'h0F;
	localparam logic [7:0] PID_MAF      = 8'h10;
	localparam logic [7:0] PID_BATTERY  = 8'h42;

	localparam logic [QTY_W-1:0] QTY_RPM      = 4'd0;
	localparam logic [QTY_W-1:0] QTY_SPEED    = 4'd1;
	localparam logic [QTY_W-1:0] QTY_THROTTLE = 4'd2;
	localparam logic [QTY_W-1:0] QTY_FUEL     = 4'd3;
	localparam logic [QTY_W-1:0] QTY_COOLANT  = 4'd4;
	localparam logic [QTY_W-1:0] QTY_LOAD     = 4'd5;
	localparam logic [QTY_W-1:0] QTY_INTAKE   = 4'd6;
	localparam logic [QTY_W-1:0] QTY_MAF      = 4'd7;
	localparam logic [QTY_W-1:0] QTY_BATTERY  = 4'd8;

	// reciprocal constants: floor(x/d) = (x*M) >> K over the operand range
	localparam logic [22:0] RECIP_255_M  = 23'h008081;
	localparam logic [22:0] RECIP_25_M   = 23'd5368710;
	localparam logic [22:0] RECIP_125_M  = 23'd2147484;
	localparam logic [22:0] TEMP_OFFSET  = 23'd10240;

	typedef struct packed {
		logic [ID_W-1:0]  frame_id;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       mode_byte;
		logic [7:0]       pid_byte;
		logic [7:0]       first_value_byte;
		logic [7:0]       second_value_byte;
	} frame_t;

	typedef struct packed {
		logic                      ok;
		logic [QTY_W-1:0]          quantity;
		logic signed [VALUE_W-1:0] value;
	} decode_t;

endpackage

@@ hdl/obdpid_if.sv @@
// Valid/ready channel interfaces for received frames and decoded results.
interface obdpid_frame_if;
	logic       valid;
	logic       ready;
	logic [28:0] frame_id;
	logic [3:0] frame_length;
	logic [7:0] mode_byte;
	logic [7:0] pid_byte;
	logic [7:0] first_value_byte;
	logic [7:0] second_value_byte;

	modport source (
		output valid, frame_id, frame_length, mode_byte, pid_byte,
		       first_value_byte, second_value_byte,
		input  ready
	);
	modport sink (
		input  valid, frame_id, frame_length, mode_byte, pid_byte,
		       first_value_byte, second_value_byte,
		output ready
	);
endinterface

interface obdpid_result_if;
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [3:0]        quantity;
	logic signed [22:0] scaled_value;
	logic [8:0]        seen_marks;

	modport source (
		output valid, accepted, quantity, scaled_value, seen_marks,
		input  ready
	);
	modport sink (
		input  valid, accepted, quantity, scaled_value, seen_marks,
		output ready
	);
endinterface

@@ hdl/obdpid_decode.sv @@
// Frame match, PID lookup and fixed-point scaling of one registered frame.
module obdpid_decode (
	input  obdpid_pkg::frame_t              frame,
	input  logic [obdpid_pkg::ID_W-1:0]     response_id,
	output obdpid_pkg::decode_t             decoded
);

	typedef enum logic [2:0] {
		KIND_RPM,
		KIND_SPEED,
		KIND_PCT,
		KIND_TEMP,
		KIND_MAF,
		KIND_BATT
	} kind_t;

	logic        match;
	logic        known;
	kind_t       kind;
	logic [3:0]  qty;
	logic [15:0] ab;
	logic [14:0] pct_base;
	logic [21:0] mul_x;
	logic [22:0] mul_m;
	logic [44:0] product;
	logic [22:0] rpm_v;
	logic [22:0] speed_v;
	logic [22:0] pct_v;
	logic [22:0] temp_v;
	logic [22:0] maf_v;
	logic [22:0] batt_v;
	logic [22:0] value_v;

	assign match = (frame.frame_id == response_id)
		&& (frame.frame_length >= obdpid_pkg::MIN_LENGTH)
		&& (frame.mode_byte == obdpid_pkg::MODE_RESPONSE);

	always_comb begin
		known = 1'b1;
		kind  = KIND_RPM;
		qty   = obdpid_pkg::QTY_RPM;
		unique case (frame.pid_byte)
			obdpid_pkg::PID_RPM: begin
				kind = KIND_RPM;   qty = obdpid_pkg::QTY_RPM;
			end
			obdpid_pkg::PID_SPEED: begin
				kind = KIND_SPEED; qty = obdpid_pkg::QTY_SPEED;
			end
			obdpid_pkg::PID_THROTTLE: begin
				kind = KIND_PCT;   qty = obdpid_pkg::QTY_THROTTLE;
			end
			obdpid_pkg::PID_FUEL: begin
				kind = KIND_PCT;   qty = obdpid_pkg::QTY_FUEL;
			end
			obdpid_pkg::PID_COOLANT: begin
				kind = KIND_TEMP;  qty = obdpid_pkg::QTY_COOLANT;
			end
			obdpid_pkg::PID_LOAD: begin
				kind = KIND_PCT;   qty = obdpid_pkg::QTY_LOAD;
			end
			obdpid_pkg::PID_INTAKE: begin
				kind = KIND_TEMP;  qty = obdpid_pkg::QTY_INTAKE;
			end
			obdpid_pkg::PID_MAF: begin
				kind = KIND_MAF;   qty = obdpid_pkg::QTY_MAF;
			end
			obdpid_pkg::PID_BATTERY: begin
				kind = KIND_BATT;  qty = obdpid_pkg::QTY_BATTERY;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign ab = {frame.first_value_byte, frame.second_value_byte};

	// percent: A*25600/255 = A*100 + floor(A*100/255)
	assign pct_base = 15'({7'd0, frame.first_value_byte} * 15'd100);

	// share one reciprocal multiplier between percent, MAF and battery
	always_comb begin
		unique case (kind)
			KIND_MAF: begin
				mul_x = {ab, 6'd0};
				mul_m = obdpid_pkg::RECIP_25_M;
			end
			KIND_BATT: begin
				mul_x = {1'b0, ab, 5'd0};
				mul_m = obdpid_pkg::RECIP_125_M;
			end
			default: begin
				mul_x = {7'd0, pct_base};
				mul_m = obdpid_pkg::RECIP_255_M;
			end
		endcase
	end

	assign product = {23'd0, mul_x} * {22'd0, mul_m};

	assign rpm_v   = {1'b0, ab[15:2], 8'd0};
	assign speed_v = {7'd0, frame.first_value_byte, 8'd0};
	assign pct_v   = {8'd0, pct_base} + {1'b0, product[44:23]};
	assign temp_v  = speed_v - obdpid_pkg::TEMP_OFFSET;
	assign maf_v   = {5'd0, product[44:27]};
	assign batt_v  = {6'd0, product[44:28]};

	always_comb begin
		unique case (kind)
			KIND_RPM:   value_v = rpm_v;
			KIND_SPEED: value_v = speed_v;
			KIND_PCT:   value_v = pct_v;
			KIND_TEMP:  value_v = temp_v;
			KIND_MAF:   value_v = maf_v;
			KIND_BATT:  value_v = batt_v;
			default:    value_v = '0;
		endcase
	end

	always_comb begin
		decoded.ok       = match && known;
		decoded.quantity = decoded.ok ? qty : obdpid_pkg::QTY_RPM;
		decoded.value    = decoded.ok ? $signed(value_v) : '0;
	end

endmodule

@@ hdl/obd_pid_response_decoder_unit.sv @@
// Top level of the OBD-II mode 01 response decoder.
// Usage:
//   frame  : valid/ready sink, one received CAN frame per beat (identifier,
//            length code, payload bytes 1 to 4).
//   result : valid/ready source, exactly one beat per frame: accepted flag,
//            quantity code, Q.8 value (zero when rejected) and the sticky
//            mask of quantities decoded since reset, including this frame.
//   cfg_write_en / cfg_write_data : writes the accepted response identifier;
//            write only while no frame is in flight.
// Path: a frame beat is taken into the input register, then moves on to the
//   result register, from which its result beat leaves.
// Throughput: one frame per cycle while result.ready stays high; the decode is
//   one shared reciprocal multiplier and a select between the two registers.
// Reset: clears both pipeline stages and the seen mask, and loads the
//   response identifier with 0x7E8.
// Stall: when result.ready is low the result register holds; the input
//   register still takes one more frame, then frame.ready drops until the
//   result beat leaves.
module obd_pid_response_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [obdpid_pkg::ID_W-1:0]       cfg_write_data,
	obdpid_frame_if.sink                      frame,
	obdpid_result_if.source                   result
);

	logic [obdpid_pkg::ID_W-1:0]    response_id_q;
	logic [obdpid_pkg::MARKS_W-1:0] seen_q;
	logic [obdpid_pkg::MARKS_W-1:0] seen_next;

	logic                 valid_s1;
	obdpid_pkg::frame_t   frame_s1;
	obdpid_pkg::decode_t  decoded;

	logic                              valid_s2;
	logic                              accepted_s2;
	logic [obdpid_pkg::QTY_W-1:0]      quantity_s2;
	logic signed [obdpid_pkg::VALUE_W-1:0] value_s2;
	logic [obdpid_pkg::MARKS_W-1:0]    marks_s2;

	logic s2_free;
	logic move_s1;
	logic take_frame;

	assign s2_free    = !valid_s2 || result.ready;
	assign move_s1    = valid_s1 && s2_free;
	assign frame.ready = !valid_s1 || s2_free;
	assign take_frame = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_id_q <= obdpid_pkg::RESPONSE_ID_RESET;
		end else if (cfg_write_en) begin
			response_id_q <= cfg_write_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_frame) begin
			frame_s1.frame_id          <= frame.frame_id;
			frame_s1.frame_length      <= frame.frame_length;
			frame_s1.mode_byte         <= frame.mode_byte;
			frame_s1.pid_byte          <= frame.pid_byte;
			frame_s1.first_value_byte  <= frame.first_value_byte;
			frame_s1.second_value_byte <= frame.second_value_byte;
		end
	end

	obdpid_decode u_decode (
		.frame       (frame_s1),
		.response_id (response_id_q),
		.decoded     (decoded)
	);

	always_comb begin
		seen_next = seen_q;
		if (decoded.ok) begin
			seen_next = seen_q | (obdpid_pkg::MARKS_W'(1) << decoded.quantity);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (move_s1) begin
			seen_q <= seen_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			accepted_s2 <= decoded.ok;
			quantity_s2 <= decoded.quantity;
			value_s2    <= decoded.value;
			marks_s2    <= seen_next;
		end
	end

	assign result.valid        = valid_s2;
	assign result.accepted     = accepted_s2;
	assign result.quantity     = quantity_s2;
	assign result.scaled_value = value_s2;
	assign result.seen_marks   = marks_s2;

endmodule
